// ===== rtl/core/f2h_pkg.sv =====
package f2h_pkg;

   // Single-precision field limits
   localparam logic [7:0] ExpSpecial  = 8'hFF;  // infinity or NaN
   localparam logic [7:0] ExpOvfTrunc = 8'd142; // above this, truncation overflows
   localparam logic [7:0] ExpOvfRound = 8'd143; // at or above this, rounding overflows
   localparam logic [7:0] ExpNormMin  = 8'd113; // smallest exponent giving a half normal
   localparam logic [7:0] ExpSubMin   = 8'd102; // smallest exponent giving a half subnormal
   localparam logic [7:0] ExpRebias   = 8'd112; // 127 - 15

   // Half-precision magnitude codes
   localparam logic [14:0] HalfInf      = 15'h7C00;
   localparam logic [14:0] HalfQuietNan = 15'h7E00;
   localparam logic [9:0]  HalfQuiet    = 10'h200;

   // Subnormal shift is SubShiftBase + offset, offset 0..10
   localparam logic [4:0] SubShiftBase = 5'd13;

   // Decoded item handed from the front end to the pipeline
   typedef struct packed {
      logic        sign;
      logic        is_sub;   // magnitude comes from the subnormal shifter
      logic [3:0]  sh_off;   // subnormal shift offset
      logic [23:0] mant;     // significand with hidden bit
      logic [14:0] base;     // magnitude before the round increment
      logic        rnd;      // round increment for the non-subnormal path
   } dec_type;

endpackage

// ===== rtl/core/fp32_to_fp16_convert.sv =====
// Single to half precision converter. Takes one 32-bit IEEE single bit pattern
// per cycle and returns the 16-bit half pattern through a three-stage pipeline
// (decode, subnormal shift, round increment); throughput is one item per clock
// while the result side does not stall. csr_wr_data picks the mode: 0 truncates
// the significand with no half subnormals, 1 rounds half-up on the magnitude,
// makes half subnormals and turns NaN into a quiet NaN. Change the mode only
// while no item is in flight.
module fp32_to_fp16_convert
   import f2h_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_single_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_half_bits
);

   logic        round_mode_ff;
   dec_type     dec;

   logic        s1_valid_ff, s1_valid_in;
   dec_type     s1_ff;
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_sign_ff;
   logic [14:0] s2_mag_ff, s2_mag_in;
   logic        s2_rnd_ff, s2_rnd_in;
   logic        s3_valid_ff, s3_valid_in;
   logic [15:0] s3_half_ff;

   logic        adv3, adv2, adv1;
   logic [4:0]  sh;
   logic [23:0] shifted;
   logic [14:0] mag_sum;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         round_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         round_mode_ff <= csr_wr_data;
      end
   end

   // Each stage moves on when the one after it is empty or moving
   assign adv3      = !s3_valid_ff || !rsp_stall;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   assign s1_valid_in = adv1 ? req_valid : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Stage 1: decode
   f2h_decode u_decode (
      .single_bits (req_single_bits),
      .round_mode  (round_mode_ff),
      .dec         (dec)
   );

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= dec;
      end
   end

   // Stage 2: subnormal shift, round bit is the last bit shifted out
   assign sh      = SubShiftBase + {1'b0, s1_ff.sh_off};
   assign shifted = s1_ff.mant >> sh;

   always_comb begin
      if (s1_ff.is_sub) begin
         s2_mag_in = {5'b0, shifted[10:1]};
         s2_rnd_in = shifted[0];
      end else begin
         s2_mag_in = s1_ff.base;
         s2_rnd_in = s1_ff.rnd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_sign_ff <= s1_ff.sign;
         s2_mag_ff  <= s2_mag_in;
         s2_rnd_ff  <= s2_rnd_in;
      end
   end

   // Stage 3: round increment, carry may run into the exponent
   assign mag_sum = s2_mag_ff + {14'b0, s2_rnd_ff};

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_half_ff <= {s2_sign_ff, mag_sum};
      end
   end

   assign rsp_valid     = s3_valid_ff;
   assign rsp_half_bits = s3_half_ff;

endmodule

// ===== rtl/core/f2h_decode.sv =====
module f2h_decode
   import f2h_pkg::*;
(
   input  logic [31:0] single_bits,
   input  logic        round_mode,
   output dec_type     dec
);

   logic [7:0]  expf;
   logic [22:0] frac;
   logic [7:0]  ne_full;
   logic [7:0]  off_full;

   assign expf     = single_bits[30:23];
   assign frac     = single_bits[22:0];
   assign ne_full  = expf - ExpRebias;
   assign off_full = ExpRebias - expf;

   // Classify the item and build the magnitude for every case but subnormals
   always_comb begin
      dec.sign   = single_bits[31];
      dec.is_sub = 1'b0;
      dec.sh_off = '0;
      dec.mant   = {1'b1, frac};
      dec.base   = '0;
      dec.rnd    = 1'b0;
      if (expf == '0) begin
         dec.base = '0;
      end else if (expf == ExpSpecial) begin
         if (round_mode) begin
            dec.base = (frac != '0) ? HalfQuietNan : HalfInf;
         end else if (frac[22:13] != '0) begin
            dec.base = HalfInf | {5'b0, frac[22:13]};
         end else if (frac != '0) begin
            dec.base = HalfInf | {5'b0, HalfQuiet};
         end else begin
            dec.base = HalfInf;
         end
      end else if (round_mode) begin
         if (expf >= ExpOvfRound) begin
            dec.base = HalfInf;
         end else if (expf >= ExpNormMin) begin
            dec.base = {ne_full[4:0], frac[22:13]};
            dec.rnd  = frac[12];
         end else if (expf >= ExpSubMin) begin
            dec.is_sub = 1'b1;
            dec.sh_off = off_full[3:0];
         end else begin
            dec.base = '0;
         end
      end else begin
         if (expf > ExpOvfTrunc) begin
            dec.base = HalfInf;
         end else if (expf >= ExpNormMin) begin
            dec.base = {ne_full[4:0], frac[22:13]};
         end else begin
            dec.base = '0;
         end
      end
   end

endmodule

// ===== dv/fp32_to_fp16_convert_test.sv =====
module fp32_to_fp16_convert_test;

   // Half magnitude codes used by the prediction
   localparam logic [15:0] HalfInfMag   = 16'h7C00;
   localparam logic [15:0] HalfQuietBit = 16'h0200;
   localparam int          ExpBias      = 127;
   localparam int          ExpRebias    = 112;

   typedef struct {
      logic [31:0] single;
      logic [15:0] half;
      logic        rounding;
   } conv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_single_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_half_bits;

   conv_result_type pending_halves[$];
   logic            round_now = 1'b0;   // mode as held by the block
   logic            steady = 1'b0;      // no idling on either side
   int              mismatches = 0;
   int              hold_cycles = 0;

   fp32_to_fp16_convert DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_single_bits(req_single_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_half_bits  (rsp_half_bits)
   );

   always #4 clock = ~clock;

   // Expected half pattern for one single pattern in the given mode
   function automatic logic [15:0] convert_half(input logic [31:0] single,
                                                input logic rounding);
      int          expf;
      int          ne;
      int          sh;
      logic [22:0] frac;
      logic [23:0] mant;
      logic [15:0] mag;
      expf = int'(single[30:23]);
      frac = single[22:0];
      if (!rounding) begin
         // truncation: no half subnormals, NaN payload kept
         if (expf == 0)
            mag = '0;
         else if (expf == 255) begin
            if (frac == 0)
               mag = HalfInfMag;
            else if (frac[22:13] == 0)
               mag = HalfInfMag | HalfQuietBit;
            else
               mag = HalfInfMag | 16'(frac[22:13]);
         end else if (expf - ExpBias > 15)
            mag = HalfInfMag;
         else if (expf - ExpBias < -14)
            mag = '0;
         else
            mag = 16'((expf - ExpRebias) << 10) | 16'(frac[22:13]);
      end else begin
         // round half-up on the magnitude
         ne = expf - ExpRebias;
         if (expf == 0)
            mag = '0;
         else if (expf == 255)
            mag = (frac != 0) ? (HalfInfMag | HalfQuietBit) : HalfInfMag;
         else if (ne >= 31)
            mag = HalfInfMag;
         else if (ne <= 0) begin
            sh = 14 - ne;
            if (sh > 24)
               mag = '0;
            else begin
               mant = {1'b1, frac};
               mag = 16'(mant >> sh);
               if (mant[sh-1])
                  mag = mag + 16'd1;
            end
         end else begin
            mag = 16'(ne << 10) | 16'(frac[22:13]);
            if (frac[12])
               mag = mag + 16'd1;
         end
      end
      return {single[31], mag[14:0]};
   endfunction

   // Random single pattern weighted towards the interesting exponents
   function automatic logic [31:0] random_single();
      int          pick;
      logic [7:0]  e;
      logic [22:0] f;
      pick = $urandom_range(0, 99);
      f = 23'($urandom);
      if (pick < 45)
         e = 8'($urandom_range(98, 146));
      else if (pick < 55)
         e = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      else
         e = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8)
         f = '0;
      else if (pick < 14)
         f = '1;
      else if (pick < 22)
         f[12:0] = 13'h1000;
      else if (pick < 30)
         f[12:0] = 13'h0FFF;
      return {1'($urandom), e, f};
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Present one item, wait for acceptance, queue its expected result
   task automatic send_single(input logic [31:0] bits);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_single_bits <= bits;
      do @(posedge clock); while (req_stall);
      pending_halves.push_back('{bits, convert_half(bits, round_now), round_now});
   endtask

   // Hold the sender off until every queued result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_halves.size() != 0);
   endtask

   task automatic write_round_mode(input logic m);
      wait_for_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      round_now = m;
   endtask

   // Truncation edge cases, run in the reset mode
   task automatic test_truncate_directed();
      logic [31:0] singles[12];
      singles = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7F80_0000,
                  32'hFF80_0000, 32'h7F80_0001, 32'h7FC0_0000, 32'h477F_FFFF,
                  32'h4780_0000, 32'h3880_0000, 32'h3800_0000, 32'hFFFF_FFFF};
      foreach (singles[i])
         send_single(singles[i]);
   endtask

   // Rounding edge cases: carries into exponent, infinity, smallest normal
   task automatic test_round_directed();
      logic [31:0] singles[13];
      write_round_mode(1'b1);
      singles = '{32'h807F_FFFF, 32'h7F80_0001, 32'hFF80_0000, 32'h477F_EFFF,
                  32'h477F_F000, 32'hC780_0000, 32'h3F80_1000, 32'h3FFF_F000,
                  32'h3800_0000, 32'hB87F_FFFF, 32'h3300_0000, 32'h32FF_FFFF,
                  32'h3F80_0FFF};
      foreach (singles[i])
         send_single(singles[i]);
   endtask

   // Random items in one mode, pausing now and then until the pipe is empty
   task automatic test_random_mode(input logic m, input int count);
      write_round_mode(m);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 99)
            wait_for_results();
         send_single(random_single());
      end
   endtask

   // Back-to-back items with no idling on either side
   task automatic test_steady_stream(input int count);
      steady = 1'b1;
      test_random_mode(1'b1, count);
      test_random_mode(1'b0, count);
      wait_for_results();
      steady = 1'b0;
   endtask

   // Short bursts with a mode write between each, same value written twice
   task automatic test_mode_toggle();
      logic modes[10];
      modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      foreach (modes[i])
         test_random_mode(modes[i], 30);
   endtask

   // Result side: stall drawn per item, compare with the oldest expectation
   always @(posedge clock) begin : check_results
      conv_result_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_halves.size() == 0)
               report_mismatch($sformatf("result %h with none outstanding", rsp_half_bits));
            else begin
               due = pending_halves.pop_front();
               if (rsp_half_bits !== due.half)
                  report_mismatch($sformatf("single %h round %0b: half %h, wanted %h",
                                            due.single, due.rounding, rsp_half_bits,
                                            due.half));
            end
            hold_cycles = steady ? 0 : $urandom_range(0, 5);
         end
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_truncate_directed();
      test_round_directed();
      test_random_mode(1'b0, 300);
      test_random_mode(1'b1, 350);
      test_steady_stream(100);
      test_mode_toggle();
      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end

endmodule
